@@ hdl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W        = 64;
    localparam int VAL_W        = 32;
    localparam int CFG_W        = 5;
    localparam int OCC_W        = 5;
    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 64;

    localparam logic [CFG_W-1:0] CAP_RESET      = 5'd16;
    localparam logic [VAL_W-1:0] GET_MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0] SET_VALUE      = 32'h0000_0000;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] value_out;
        logic                    evicted;
        logic [OCC_W-1:0]        occupancy;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic match;
        logic touch;
        logic insert;
        logic wr_val;
        logic rd_val;
    } cmd_t;

    typedef struct packed {
        logic is_set;
        logic found;
    } st_t;

endpackage

@@ hdl/lkv_req_if.sv @@
// ----------------------------------------------------------------------------
// lkv_req_if
// request channel: valid/ready handshake carrying one request word
// ----------------------------------------------------------------------------
interface lkv_req_if;

    logic          valid;
    logic          ready;
    lkv_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/lkv_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lkv_rsp_if
// response channel: valid/ready handshake carrying one result word
// ----------------------------------------------------------------------------
interface lkv_rsp_if;

    logic          valid;
    logic          ready;
    lkv_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/lkv_ram.sv @@
// ----------------------------------------------------------------------------
// lkv_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lkv_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkv_ctrl
// request sequencer: accept, match, update, respond
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  logic         rsp_ready,
    input  lkv_pkg::st_t st,
    output lkv_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.touch = st.found;
                if (st.is_set)
                begin
                    cmd.wr_val = 1'b1;
                    cmd.insert = !st.found;
                end
                else
                begin
                    cmd.rd_val = st.found;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/lkv_dp.sv @@
// ----------------------------------------------------------------------------
// lkv_dp
// entry store: key cam, recency ranks, value ram and result assembly
// ----------------------------------------------------------------------------
module lkv_dp #(
    parameter int CAPACITY = lkv_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lkv_pkg::cmd_t              cmd,
    output lkv_pkg::st_t               st,
    input  lkv_pkg::req_t              req_data,
    output lkv_pkg::rsp_t              rsp_data,
    input  logic                       cfg_we,
    input  logic [lkv_pkg::CFG_W-1:0]  cfg_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LIM_W = (CNT_W > lkv_pkg::CFG_W) ? CNT_W : lkv_pkg::CFG_W;

    // entry state
    logic [CAPACITY-1:0]           valid_reg;
    logic [KEY_BITS-1:0]           key_reg   [CAPACITY];
    logic [IDX_W-1:0]              rank_reg  [CAPACITY];
    logic [CNT_W-1:0]              count_reg;
    logic [lkv_pkg::CFG_W-1:0]     cap_reg;

    // request word
    logic                          func_reg;
    logic [KEY_BITS-1:0]           rkey_reg;
    logic [lkv_pkg::VAL_W-1:0]     rval_reg;

    // lookup results
    logic                          found_reg;
    logic                          full_reg;
    logic                          evicted_reg;
    logic [CAPACITY-1:0]           found_oh_reg;
    logic [CAPACITY-1:0]           slot_oh_reg;
    logic [IDX_W-1:0]              found_idx_reg;
    logic [IDX_W-1:0]              wr_idx_reg;
    logic [IDX_W-1:0]              found_rank_reg;

    // lookup logic
    logic [CAPACITY-1:0]           match_oh;
    logic [CAPACITY-1:0]           victim_oh;
    logic [CAPACITY-1:0]           free_vec;
    logic [CAPACITY-1:0]           free_oh;
    logic [IDX_W-1:0]              match_idx;
    logic [IDX_W-1:0]              victim_idx;
    logic [IDX_W-1:0]              free_idx;
    logic [IDX_W-1:0]              match_rank;
    logic [IDX_W-1:0]              last_rank;
    logic [LIM_W-1:0]              cap_x;
    logic [LIM_W-1:0]              limit;
    logic                          full;

    logic [lkv_pkg::VAL_W-1:0]     ram_rdata;

    assign last_rank = IDX_W'(count_reg - 1'b1);
    assign free_vec  = ~valid_reg;
    assign free_oh   = free_vec & (~free_vec + CAPACITY'(1));

    always_comb
    begin
        match_oh   = '0;
        victim_oh  = '0;
        match_idx  = '0;
        victim_idx = '0;
        free_idx   = '0;
        match_rank = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_oh[i]  = valid_reg[i] && (key_reg[i] == rkey_reg);
            victim_oh[i] = valid_reg[i] && (rank_reg[i] == last_rank);
            if (match_oh[i])
            begin
                match_idx  = match_idx | IDX_W'(i);
                match_rank = match_rank | rank_reg[i];
            end
            if (victim_oh[i])
            begin
                victim_idx = victim_idx | IDX_W'(i);
            end
            if (free_oh[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    // capacity in use, clamped to 1..CAPACITY
    assign cap_x = LIM_W'(cap_reg);
    assign limit = (cap_x == '0) ? LIM_W'(1) :
                   ((cap_x > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : cap_x);
    assign full  = LIM_W'(count_reg) >= limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            count_reg   <= '0;
            cap_reg     <= lkv_pkg::CAP_RESET;
            found_reg   <= 1'b0;
            full_reg    <= 1'b0;
            evicted_reg <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                evicted_reg <= 1'b0;
            end
            if (cmd.match)
            begin
                found_reg <= |match_oh;
                full_reg  <= full;
            end
            if (cmd.touch)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (found_oh_reg[i])
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < found_rank_reg))
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
            end
            if (cmd.insert)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (slot_oh_reg[i])
                    begin
                        valid_reg[i] <= 1'b1;
                        rank_reg[i]  <= '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
                evicted_reg <= full_reg;
                if (!full_reg)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= req_data.func;
            rkey_reg <= req_data.key[KEY_BITS-1:0];
            rval_reg <= req_data.value;
        end
        if (cmd.match)
        begin
            found_oh_reg   <= match_oh;
            slot_oh_reg    <= full ? victim_oh : free_oh;
            found_idx_reg  <= match_idx;
            found_rank_reg <= match_rank;
            wr_idx_reg     <= (|match_oh) ? match_idx : (full ? victim_idx : free_idx);
        end
        if (cmd.insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (slot_oh_reg[i])
                begin
                    key_reg[i] <= rkey_reg;
                end
            end
        end
    end

    lkv_ram #(
        .WIDTH (lkv_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (cmd.wr_val),
        .waddr (wr_idx_reg),
        .wdata (rval_reg),
        .re    (cmd.rd_val),
        .raddr (found_idx_reg),
        .rdata (ram_rdata)
    );

    assign st.is_set = (func_reg == lkv_pkg::FUNC_SET);
    assign st.found  = found_reg;

    always_comb
    begin
        rsp_data.hit       = found_reg;
        rsp_data.evicted   = evicted_reg;
        rsp_data.occupancy = lkv_pkg::OCC_W'(count_reg);
        if (func_reg == lkv_pkg::FUNC_SET)
        begin
            rsp_data.value_out = lkv_pkg::SET_VALUE;
        end
        else if (found_reg)
        begin
            rsp_data.value_out = ram_rdata;
        end
        else
        begin
            rsp_data.value_out = lkv_pkg::GET_MISS_VALUE;
        end
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("occupancy count differs from valid entries");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= CAPACITY)
        else $error("occupancy above capacity");

    a_touch_one_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.touch |-> $onehot(found_oh_reg))
        else $error("touch without a single matching entry");

    a_insert_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> $onehot(slot_oh_reg))
        else $error("insert without a single target slot");

    a_evict_grows_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && full_reg) |=> $stable(count_reg))
        else $error("eviction changed occupancy");

endmodule

@@ hdl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// Each request word is a get or a set on a key. Keys sit in a register cam
// compared in parallel; values sit in a small ram with registered read, and
// per-entry recency ranks pick the victim. A request goes through the states
// accept, cam match, update and value read, and response, in that order, and
// the block accepts no new request word until the result word has been taken;
// the value ram's registered read is why the response state follows the update
// state. No clearing pass after reset. The capacity register may be written
// only while no request is in flight.
module lru_key_value_cache #(
    parameter int CAPACITY = lkv_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    lkv_req_if.sink                   req,
    lkv_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [lkv_pkg::CFG_W-1:0] cfg_data
);

    lkv_pkg::cmd_t cmd;
    lkv_pkg::st_t  st;

    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    lkv_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .req_data (req.data),
        .rsp_data (rsp.data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

endmodule

@@ tb/lru_key_value_cache_tb.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking testbench for the lru key-value cache. A behavioral copy of
// the cache (keys, values, recency ranks, occupancy, capacity register)
// predicts the result word of every accepted request. A checker compares each
// result word field by field against the oldest prediction. Directed tests
// cover capacity zero and one, key and value extremes, and lowering the
// capacity below occupancy. Random traffic follows, with random stalls on
// both channels in its first two phases and several capacity settings.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS     = lkv_pkg::CAPACITY_DEF;
    localparam int KEY_BITS      = lkv_pkg::KEY_BITS_DEF;
    localparam int POOL_SIZE     = 20;
    localparam int SEG_WORDS     = 180;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;

    localparam logic [lkv_pkg::KEY_W-1:0] KEY_MASK =
        {lkv_pkg::KEY_W{1'b1}} >> (lkv_pkg::KEY_W - KEY_BITS);

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [lkv_pkg::CFG_W-1:0] cfg_data;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    lru_key_value_cache dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // cache image
    bit                        slot_valid [NUM_SLOTS] = '{default: 1'b0};
    logic [lkv_pkg::KEY_W-1:0] slot_key   [NUM_SLOTS];
    logic [lkv_pkg::VAL_W-1:0] slot_val   [NUM_SLOTS];
    int                        slot_rank  [NUM_SLOTS] = '{default: 0};
    int                        slot_count = 0;
    logic [lkv_pkg::CFG_W-1:0] cap_reg    = lkv_pkg::CAP_RESET;

    lkv_pkg::rsp_t             due_rsp [$];
    logic [lkv_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    int                        src_gap_pct = 0;
    int                        snk_gap_pct = 0;
    int                        stall_cycles = 0;
    bit                        failed = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= snk_gap_pct);
        end
    end

    function automatic void make_most_recent(int s);
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
            if (slot_valid[i] && slot_rank[i] < slot_rank[s])
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic lkv_pkg::rsp_t cache_access(lkv_pkg::req_t w);
        lkv_pkg::rsp_t             r;
        logic [lkv_pkg::KEY_W-1:0] k;
        int                        i;
        int                        found;
        int                        slot;
        int                        best;
        int                        lim;
        r     = '0;
        k     = w.key & KEY_MASK;
        found = -1;
        for (i = 0; i < NUM_SLOTS; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == k)
                found = i;
        lim = cap_reg;
        if (lim < 1)
            lim = 1;
        if (lim > NUM_SLOTS)
            lim = NUM_SLOTS;
        if (w.func == lkv_pkg::FUNC_GET)
        begin
            if (found >= 0)
            begin
                r.hit       = 1'b1;
                r.value_out = slot_val[found];
                make_most_recent(found);
            end
            else
                r.value_out = lkv_pkg::GET_MISS_VALUE;
        end
        else if (found >= 0)
        begin
            r.hit           = 1'b1;
            r.value_out     = lkv_pkg::SET_VALUE;
            slot_val[found] = w.value;
            make_most_recent(found);
        end
        else
        begin
            r.value_out = lkv_pkg::SET_VALUE;
            slot        = -1;
            best        = 0;
            if (slot_count >= lim)
            begin
                for (i = 0; i < NUM_SLOTS; i++)
                    if (slot_valid[i] && (slot < 0 || slot_rank[i] > best))
                    begin
                        slot = i;
                        best = slot_rank[i];
                    end
                if (slot >= 0)
                begin
                    slot_valid[slot] = 1'b0;
                    slot_count--;
                    r.evicted = 1'b1;
                end
            end
            if (slot < 0)
                for (i = NUM_SLOTS - 1; i >= 0; i--)
                    if (!slot_valid[i])
                        slot = i;
            if (slot >= 0)
            begin
                for (i = 0; i < NUM_SLOTS; i++)
                    if (slot_valid[i])
                        slot_rank[i]++;
                slot_valid[slot] = 1'b1;
                slot_key[slot]   = k;
                slot_val[slot]   = w.value;
                slot_rank[slot]  = 0;
                slot_count++;
            end
        end
        r.occupancy = slot_count[lkv_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic send_word(logic fn, logic [lkv_pkg::KEY_W-1:0] k,
                             logic [lkv_pkg::VAL_W-1:0] v);
        lkv_pkg::req_t w;
        w.func  = fn;
        w.key   = k;
        w.value = v;
        while ($urandom_range(99) < src_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        due_rsp.push_back(cache_access(w));
    endtask

    task automatic drain_and_settle();
        req_ch.valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [lkv_pkg::CFG_W-1:0] cap);
        drain_and_settle();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cap_reg = cap;
    endtask

    function automatic logic [lkv_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic check_field(string name, logic [lkv_pkg::VAL_W-1:0] want,
                               logic [lkv_pkg::VAL_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        lkv_pkg::rsp_t got;
        lkv_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (due_rsp.size() == 0)
            begin
                $display("%0t unexpected result word: expected none actual %p", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = due_rsp.pop_front();
                check_field("hit", want.hit, got.hit);
                check_field("value_out", want.value_out, got.value_out);
                check_field("evicted", want.evicted, got.evicted);
                check_field("occupancy", want.occupancy, got.occupancy);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // capacity 0 acts as 1; a new key then evicts the only entry
    task automatic test_capacity_zero_and_one();
        write_capacity(5'd0);
        send_word(lkv_pkg::FUNC_GET, 64'h11, 32'h0);
        send_word(lkv_pkg::FUNC_SET, 64'h11, 32'h1234_5678);
        send_word(lkv_pkg::FUNC_SET, 64'h22, 32'h0BAD_F00D);
        send_word(lkv_pkg::FUNC_GET, 64'h11, 32'h0);
        send_word(lkv_pkg::FUNC_GET, 64'h22, 32'hDEAD_BEEF);
        write_capacity(5'd1);
        send_word(lkv_pkg::FUNC_SET, 64'h11, 32'h5555_AAAA);
        send_word(lkv_pkg::FUNC_GET, 64'h11, 32'h0);
    endtask

    // capacity above the slot count, extreme keys and values
    task automatic test_field_extremes();
        write_capacity(5'd31);
        send_word(lkv_pkg::FUNC_SET, 64'h0, 32'h8000_0000);
        send_word(lkv_pkg::FUNC_SET, {lkv_pkg::KEY_W{1'b1}}, 32'h7FFF_FFFF);
        send_word(lkv_pkg::FUNC_GET, {lkv_pkg::KEY_W{1'b1}}, 32'hFFFF_FFFF);
        send_word(lkv_pkg::FUNC_GET, 64'h0, 32'h0);
        send_word(lkv_pkg::FUNC_SET, 64'h0, 32'hFFFF_FFFF);
        send_word(lkv_pkg::FUNC_GET, 64'h0, 32'h0);
    endtask

    // capacity below occupancy: inserts evict one entry each
    task automatic test_capacity_shrink();
        write_capacity(5'd2);
        send_word(lkv_pkg::FUNC_SET, 64'hA5A5_0000_0000_5A5A, 32'h0000_0001);
        send_word(lkv_pkg::FUNC_GET, 64'h11, 32'h0);
        send_word(lkv_pkg::FUNC_SET, 64'h5A5A_FFFF_FFFF_A5A5, 32'h0000_0002);
    endtask

    task automatic test_random_traffic();
        int                        src_pct [3] = '{24, 47, 0};
        int                        snk_pct [3] = '{47, 24, 0};
        logic [lkv_pkg::CFG_W-1:0] caps [9] = '{5'd6, 5'd12, 5'd3, 5'd16, 5'd0,
                                                5'd9, 5'd31, 5'd1, 5'd20};
        logic [lkv_pkg::KEY_W-1:0] k;
        int                        ph;
        int                        seg;
        int                        i;
        for (ph = 0; ph < 3; ph++)
        begin
            drain_and_settle();
            src_gap_pct = src_pct[ph];
            snk_gap_pct = snk_pct[ph];
            for (i = 0; i < POOL_SIZE; i++)
                key_pool[i] = {$urandom(), $urandom()};
            for (seg = 0; seg < 3; seg++)
            begin
                write_capacity(caps[ph * 3 + seg]);
                repeat (SEG_WORDS)
                begin
                    if ($urandom_range(99) < 85)
                        k = key_pool[$urandom_range(POOL_SIZE - 1)];
                    else
                        k = {$urandom(), $urandom()};
                    send_word(logic'($urandom_range(1)), k, pick_value());
                end
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_data     <= lkv_pkg::CAP_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_gap_pct = 24;
        snk_gap_pct = 47;
        test_capacity_zero_and_one();
        test_field_extremes();
        test_capacity_shrink();
        test_random_traffic();
        drain_and_settle();
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hdl/lkv_pkg.sv
hdl/lkv_req_if.sv
hdl/lkv_rsp_if.sv
hdl/lkv_ram.sv
hdl/lkv_ctrl.sv
hdl/lkv_dp.sv
hdl/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
